@@ rtl/bdqs_pkg.sv @@
// ----------------------------------------------------------------------------
// bdqs_pkg
// shared constants, operation codes and cell control type for the bounded
// deque with search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdqs_pkg;

	// number of cells in the row
	localparam int CAPACITY = 16;
	// width of a stored value
	localparam int VAL_W    = 32;
	// width of the occupancy counter, able to hold CAPACITY itself
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// width of the count field on the result word
	localparam int COUNT_W  = 5;
	// width of the operation field
	localparam int FUNC_W   = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_BACK  = 2'd1,
		FN_POP_FRONT  = 2'd2,
		FN_SEARCH     = 2'd3
	} func_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic shift_r; // push front: every cell takes its left neighbour
		logic shift_l; // pop front: every cell takes its right neighbour
		logic load;    // push back: the tail cell takes the operand
	} cell_ctl_t;

endpackage

@@ rtl/bdqs_cell.sv @@
// ----------------------------------------------------------------------------
// bdqs_cell
// one storage cell of the deque row: holds a value, shifts with its
// neighbours, takes the operand as tail cell and compares against the search key
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdqs_cell import bdqs_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic             tail,
	input  logic             occupied,
	input  logic [VAL_W-1:0] key,
	input  logic [VAL_W-1:0] left_val,
	input  logic [VAL_W-1:0] right_val,
	output logic [VAL_W-1:0] val,
	output logic             hit
);

	logic [VAL_W-1:0] val_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		priority if (ctl.shift_r) begin
			val_q <= left_val;
		end else if (ctl.shift_l) begin
			val_q <= right_val;
		end else if (ctl.load && tail) begin
			val_q <= key;
		end
	end

	assign val = val_q;
	assign hit = occupied && (val_q == key);

endmodule

@@ rtl/bounded_deque_with_search.sv @@
// output: a result word appears in the output register in the cycle after its
// input word is accepted
// throughput: one word per cycle, set by the update of the cell
// row; input stalls only while a finished result waits downstream
// reset: arst_n clears the occupancy and the output valid; cell contents are
// left as they are and only occupied cells are ever read
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded deque of signed 32-bit values held in a shifting row of cells,
// with push front, push back, pop front and a parallel search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_deque_with_search import bdqs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [FUNC_W-1:0]         func,
	input  logic signed [VAL_W-1:0]   operand,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VAL_W-1:0]   popped,
	output logic                      found,
	output logic                      fault,
	output logic [COUNT_W-1:0]        count
);

	// ------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------
	// the front of the deque always sits in cell 0, so no front pointer is
	// needed: push front shifts the row right, pop front shifts it left
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] occ_d;

	logic                    out_valid_q;
	logic [VAL_W-1:0]        popped_q;
	logic                    found_q;
	logic                    fault_q;
	logic [CNT_W-1:0]        occ_out_q;

	// ------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------
	logic  in_acc;
	func_t fn;

	// hold the input while the result register is full and not drained
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign fn       = func_t'(func);

	// ------------------------------------------------------------------
	// cell row
	// ------------------------------------------------------------------
	logic [VAL_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	logic [CAPACITY-1:0] cell_tail;
	logic [CAPACITY-1:0] cell_occ;
	cell_ctl_t ctl;

	logic full;
	logic empty;

	assign full  = (occ_q == CNT_W'(CAPACITY));
	assign empty = (occ_q == '0);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [VAL_W-1:0] left_v;
			logic [VAL_W-1:0] right_v;

			// cell 0 takes the operand on a push front
			if (gi == 0) begin : g_first
				assign left_v = operand;
			end else begin : g_mid
				assign left_v = cell_val[gi-1];
			end

			// the last cell keeps its value on a pop; it leaves the occupied range
			if (gi == CAPACITY - 1) begin : g_last
				assign right_v = cell_val[gi];
			end else begin : g_inner
				assign right_v = cell_val[gi+1];
			end

			assign cell_tail[gi] = (occ_q == CNT_W'(gi));
			assign cell_occ[gi]  = (CNT_W'(gi) < occ_q);

			bdqs_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.tail      (cell_tail[gi]),
				.occupied  (cell_occ[gi]),
				.key       (operand),
				.left_val  (left_v),
				.right_val (right_v),
				.val       (cell_val[gi]),
				.hit       (cell_hit[gi])
			);
		end
	endgenerate

	// ------------------------------------------------------------------
	// operation decode
	// ------------------------------------------------------------------
	logic [VAL_W-1:0] popped_d;
	logic             found_d;
	logic             fault_d;

	always_comb begin
		ctl      = '0;
		occ_d    = occ_q;
		popped_d = '0;
		found_d  = 1'b0;
		fault_d  = 1'b0;
		unique case (fn)
			FN_PUSH_FRONT: begin
				if (full) begin
					fault_d = 1'b1;
				end else begin
					ctl.shift_r = in_acc;
					occ_d       = occ_q + 1'b1;
				end
			end
			FN_PUSH_BACK: begin
				if (full) begin
					fault_d = 1'b1;
				end else begin
					ctl.load = in_acc;
					occ_d    = occ_q + 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (empty) begin
					fault_d = 1'b1;
				end else begin
					ctl.shift_l = in_acc;
					popped_d    = cell_val[0];
					occ_d       = occ_q - 1'b1;
				end
			end
			FN_SEARCH: begin
				// every occupied cell compares at once
				found_d = |cell_hit;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// occupancy register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_acc) begin
			occ_q <= occ_d;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			popped_q  <= popped_d;
			found_q   <= found_d;
			fault_q   <= fault_d;
			occ_out_q <= occ_d;
		end
	end

	assign out_valid = out_valid_q;
	assign popped    = popped_q;
	assign found     = found_q;
	assign fault     = fault_q;
	// count field wraps for a row wider than the field can show
	assign count     = COUNT_W'(occ_out_q);

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && fn == FN_POP_FRONT && !empty) |=> (occ_q == $past(occ_q) - 1'b1))
		else $error("pop did not shrink occupancy");

	a_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fault_q) |-> (!found_q && popped_q == '0))
		else $error("fault word carries data");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (occ_out_q == occ_q))
		else $error("result count differs from occupancy");
`endif

endmodule
